// ===== design/pwp_pkg.sv =====
`default_nettype none

package pwp_pkg;

	// parameter defaults
	localparam int SEGMENTS_DEF   = 64;
	localparam int MAX_DEGREE_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int VAL_W = 32;

	typedef logic signed [VAL_W-1:0] q_t;

	// clipped value with its overflow flag
	typedef struct packed {
		q_t   val;
		logic sat;
	} sat_t;

	// one segment header as stored
	typedef struct packed {
		q_t         seg_start;
		q_t         seg_end;
		q_t         seg_base;
		logic [3:0] seg_degree;
	} hdr_t;

	// controls for the shared multiply-add unit
	typedef struct packed {
		logic mul_en;
		logic use_addend;
	} mac_ctrl_t;

	localparam logic signed [63:0] MAX_V = 64'sd2147483647;
	localparam logic signed [63:0] MIN_V = -64'sd2147483648;

	function automatic sat_t clip_val(input logic signed [63:0] v);
		sat_t r;
		if (v > MAX_V) begin
			r.val = q_t'(MAX_V);
			r.sat = 1'b1;
		end else if (v < MIN_V) begin
			r.val = q_t'(MIN_V);
			r.sat = 1'b1;
		end else begin
			r.val = q_t'(v);
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/pwp_store.sv =====
`default_nettype none

module pwp_store
	import pwp_pkg::*;
#(
	parameter int SEGMENTS   = SEGMENTS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   hdr_we,
	input  wire logic [$clog2(SEGMENTS)-1:0]            hdr_waddr,
	input  wire hdr_t                                   hdr_wdata,
	input  wire logic                                   hdr_re,
	input  wire logic [$clog2(SEGMENTS)-1:0]            hdr_raddr,
	output hdr_t                                        hdr_rdata,
	input  wire logic                                   coef_we,
	input  wire logic [$clog2(SEGMENTS*MAX_DEGREE)-1:0] coef_waddr,
	input  wire q_t                                     coef_wdata,
	input  wire logic                                   coef_re,
	input  wire logic [$clog2(SEGMENTS*MAX_DEGREE)-1:0] coef_raddr,
	output q_t                                          coef_rdata
);

	localparam int COEF_DEPTH = SEGMENTS * MAX_DEGREE;

	hdr_t hdr_mem [SEGMENTS];
	q_t   coef_mem [COEF_DEPTH];
	hdr_t hdr_rdata_q;
	q_t   coef_rdata_q;

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_waddr] <= hdr_wdata;
		end
		if (hdr_re) begin
			hdr_rdata_q <= hdr_mem[hdr_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		if (coef_re) begin
			coef_rdata_q <= coef_mem[coef_raddr];
		end
	end

	assign hdr_rdata  = hdr_rdata_q;
	assign coef_rdata = coef_rdata_q;

endmodule

`default_nettype wire

// ===== design/pwp_mac.sv =====
`default_nettype none

module pwp_mac
	import pwp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire mac_ctrl_t ctrl,
	input  wire q_t        acc,
	input  wire q_t        t,
	input  wire q_t        addend,
	output sat_t           res
);

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [63:0] prod_q;
	logic signed [63:0] rnd;
	logic signed [63:0] sum;

	// product registered before rounding
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= 64'(acc) * 64'(t);
		end
	end

	// round half up, floor shift, add the next coefficient when use_addend is set, clip
	always_comb begin
		rnd = (prod_q + HALF) >>> FRAC_BITS;
		sum = rnd + (ctrl.use_addend ? 64'(addend) : 64'sd0);
		res = clip_val(sum);
	end

endmodule

`default_nettype wire

// ===== design/piecewise_poly_evaluator.sv =====
`default_nettype none

// Piecewise polynomial evaluator over a table of up to SEGMENTS segments in signed Q16.16.
// Items come in on start while busy is low. Command 0 writes a segment header and command 1
// writes one coefficient; both raise no busy and give no result. Command 3 is dropped.
// Command 2 is a query: busy rises for its duration, and its one result is shown on
// func_value, not_found, hit_segment and saturated for exactly one cycle with done high.
// The receiver cannot stall, so done must be taken when it comes. For each binary-search
// probe a query does one header memory read, then one bound compare; on a hit it then
// loads the top coefficient, runs each coefficient through the shared 32x32 multiply-add
// unit (product register, then round/add/clip) and adds the base, and the result is
// registered with done. A miss ends when the search range is empty. The memories come out
// of reset holding nothing; a segment must be written before a query can reach it.
// Configuration (cfg_we, cfg_index, cfg_data) may only be written while no query is
// running.
module piecewise_poly_evaluator
	import pwp_pkg::*;
#(
	parameter int SEGMENTS   = SEGMENTS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  segment_index,
	input  wire logic [2:0]  coeff_slot,
	input  wire q_t          seg_start,
	input  wire q_t          seg_end,
	input  wire q_t          seg_base,
	input  wire logic [3:0]  seg_degree,
	input  wire q_t          coeff_value,
	input  wire q_t          query_x,
	// result channel
	output logic             done,
	output q_t               func_value,
	output logic             not_found,
	output logic [5:0]       hit_segment,
	output logic             saturated,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int IDX_W   = $clog2(SEGMENTS);
	localparam int CNT_W   = $clog2(SEGMENTS + 1);
	localparam int CADDR_W = $clog2(SEGMENTS * MAX_DEGREE);
	localparam int DEG_W   = $clog2(MAX_DEGREE + 1);

	localparam logic [1:0] CMD_HDR   = 2'd0;
	localparam logic [1:0] CMD_COEF  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic REG_SEGS = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_CMP    = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_ADD    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	// configuration registers
	logic [6:0] segs_in_use_q;
	logic [7:0] tol_q;

	// sequencer state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic [DEG_W-1:0] k_q;
	q_t               x_q;
	q_t               t_q;
	q_t               acc_q;
	logic             sat_q;

	// result registers
	logic       done_q;
	q_t         func_value_q;
	logic       not_found_q;
	logic [5:0] hit_q;
	logic       saturated_q;

	// memory interface
	logic               hdr_we;
	logic [IDX_W-1:0]   hdr_waddr;
	hdr_t               hdr_wdata;
	logic               hdr_re;
	logic [IDX_W-1:0]   hdr_raddr;
	hdr_t               hdr_rdata;
	logic               coef_we;
	logic [CADDR_W-1:0] coef_waddr;
	logic               coef_re;
	logic [CADDR_W-1:0] coef_raddr;
	q_t                 coef_rdata;

	// shared multiply-add unit
	mac_ctrl_t mac_ctrl;
	sat_t      mac_res;

	logic               accept;
	logic [CNT_W-1:0]   n_eff;
	logic [CNT_W:0]     lo_hi_sum;
	logic [IDX_W-1:0]   mid_d;
	logic               range_empty;
	logic signed [33:0] x34;
	logic signed [33:0] start34;
	logic signed [33:0] end34;
	logic signed [33:0] tol34;
	logic               below;
	logic               above;
	sat_t               t_clip;
	logic [DEG_W-1:0]   deg_eff;
	logic [DEG_W-1:0]   slot_sel;
	sat_t               fin_clip;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// table writes land the same cycle the item is taken
	assign hdr_we    = accept && (cmd == CMD_HDR) && (32'(segment_index) < SEGMENTS);
	assign hdr_waddr = IDX_W'(segment_index);
	assign hdr_wdata = '{seg_start: seg_start, seg_end: seg_end, seg_base: seg_base,
		seg_degree: seg_degree};
	assign coef_we    = accept && (cmd == CMD_COEF) && (32'(segment_index) < SEGMENTS)
		&& (32'(coeff_slot) < MAX_DEGREE);
	assign coef_waddr = CADDR_W'(32'(segment_index) * MAX_DEGREE + 32'(coeff_slot));

	// segment count clamped to the table size
	assign n_eff = (32'(segs_in_use_q) > SEGMENTS) ? CNT_W'(SEGMENTS) : CNT_W'(segs_in_use_q);

	// bisection probe
	assign lo_hi_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_d       = IDX_W'(lo_hi_sum >> 1);
	assign range_empty = (lo_q >= hi_q);
	assign hdr_re      = (state_q == ST_SEARCH) && !range_empty;
	assign hdr_raddr   = mid_d;

	// bound compares at 34 bits so the tolerance never wraps
	always_comb begin
		x34     = 34'(x_q);
		start34 = 34'($signed(hdr_rdata.seg_start));
		end34   = 34'($signed(hdr_rdata.seg_end));
		tol34   = $signed({26'd0, tol_q});
		below   = x34 < (start34 - tol34);
		above   = x34 > (end34 + tol34);
		t_clip  = clip_val(64'(x34 - start34));
		deg_eff = (32'(hdr_rdata.seg_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
			: DEG_W'(hdr_rdata.seg_degree);
		fin_clip = clip_val(64'($signed(hdr_rdata.seg_base)) + 64'(acc_q));
	end

	// coefficient read: top one on a hit, then one ahead of each Horner step
	always_comb begin
		case (state_q)
			ST_CMP: begin
				slot_sel = deg_eff - DEG_W'(1);
				coef_re  = !below && !above && (deg_eff != '0);
			end
			ST_LOAD: begin
				slot_sel = k_q - DEG_W'(1);
				coef_re  = (k_q != '0);
			end
			ST_ADD: begin
				slot_sel = k_q - DEG_W'(1) - DEG_W'(1);
				coef_re  = (k_q > DEG_W'(1));
			end
			default: begin
				slot_sel = '0;
				coef_re  = 1'b0;
			end
		endcase
	end

	assign coef_raddr = CADDR_W'(32'(mid_q) * MAX_DEGREE + 32'(slot_sel));

	assign mac_ctrl.mul_en     = (state_q == ST_MUL);
	assign mac_ctrl.use_addend = (k_q != '0);

	pwp_store #(
		.SEGMENTS   (SEGMENTS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_store (
		.clk        (clk),
		.hdr_we     (hdr_we),
		.hdr_waddr  (hdr_waddr),
		.hdr_wdata  (hdr_wdata),
		.hdr_re     (hdr_re),
		.hdr_raddr  (hdr_raddr),
		.hdr_rdata  (hdr_rdata),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coeff_value),
		.coef_re    (coef_re),
		.coef_raddr (coef_raddr),
		.coef_rdata (coef_rdata)
	);

	pwp_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.acc    (acc_q),
		.t      (t_q),
		.addend (coef_rdata),
		.res    (mac_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_in_use_q <= 7'd1;
			tol_q         <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEGS: segs_in_use_q <= cfg_data[6:0];
				REG_TOL:  tol_q         <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_QUERY)) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// empty range: the point is not covered
					if (range_empty) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (below || above) begin
						state_q <= ST_SEARCH;
					end else if (deg_eff == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD: begin
					// the step with no coefficient to add is the last one
					state_q <= (k_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of one query
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= query_x;
				lo_q  <= '0;
				hi_q  <= n_eff;
				sat_q <= 1'b0;
			end
			ST_SEARCH: begin
				mid_q <= mid_d;
			end
			ST_CMP: begin
				if (below) begin
					hi_q <= CNT_W'(mid_q);
				end else if (above) begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					t_q   <= t_clip.val;
					sat_q <= t_clip.sat;
					acc_q <= '0;
					k_q   <= deg_eff - DEG_W'(1);
				end
			end
			ST_LOAD: begin
				acc_q <= coef_rdata;
			end
			ST_ADD: begin
				acc_q <= mac_res.val;
				sat_q <= sat_q | mac_res.sat;
				if (k_q != '0) begin
					k_q <= k_q - DEG_W'(1);
				end
			end
			default: ;
		endcase
	end

	// result registers, shown for one cycle with done
	always_ff @(posedge clk) begin
		if ((state_q == ST_SEARCH) && range_empty) begin
			func_value_q <= '0;
			not_found_q  <= 1'b1;
			hit_q        <= 6'd0;
			saturated_q  <= 1'b0;
		end else if (state_q == ST_FIN) begin
			func_value_q <= fin_clip.val;
			not_found_q  <= 1'b0;
			hit_q        <= 6'(mid_q);
			saturated_q  <= sat_q | fin_clip.sat;
		end
	end

	assign done        = done_q;
	assign func_value  = func_value_q;
	assign not_found   = not_found_q;
	assign hit_segment = hit_q;
	assign saturated   = saturated_q;

	// a result only ever shows once the query has finished
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while a query is still running");

	// a taken query always occupies the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_QUERY)) |=> busy)
		else $error("query taken without going busy");

	// header and coefficient writes never start work
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((cmd == CMD_HDR) || (cmd == CMD_COEF))) |=> (!busy && !done))
		else $error("table write produced activity");

	// a miss reports zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && not_found) |-> ((func_value == '0) && (hit_segment == 6'd0) && !saturated))
		else $error("miss result not cleared");

endmodule

`default_nettype wire
